// ===== hw/rtl/lrv_pkg.sv =====
// Shared types, register codes, reset values and the sine table builder
// for the lidar repulsion vector core. No dependencies.
`default_nettype none

package lrv_pkg;

   // Reset values of the configuration registers.
   localparam logic [15:0] RST_SAFETY_DISTANCE = 16'd1000;
   localparam logic [15:0] RST_MIN_DISTANCE    = 16'd180;
   localparam logic [26:0] RST_MIN_THRESHOLD   = 27'd1000;
   localparam logic [15:0] RST_GAIN_P          = 16'd128;
   localparam logic [15:0] RST_GAIN_D          = 16'd0;
   localparam logic [15:0] RST_START_ANGLE     = 16'd0;
   localparam logic [15:0] RST_ANGLE_STEP      = 16'd64;

   // Default build parameters.
   localparam int DEF_TRIG_TABLE_BITS = 10;
   localparam int DEF_QUEUE_DEPTH     = 4;

   // Width of the scan sums and their limits.
   localparam int SUM_W = 28;

   // pi/2 in Q30.
   localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_SAFETY_DISTANCE = 3'd0,
      REG_MIN_DISTANCE    = 3'd1,
      REG_MIN_THRESHOLD   = 3'd2,
      REG_GAIN_P          = 3'd3,
      REG_GAIN_D          = 3'd4,
      REG_START_ANGLE     = 3'd5,
      REG_ANGLE_STEP      = 3'd6
   } reg_index_type;

   // Configuration as seen by the front and back parts.
   typedef struct packed {
      logic [15:0] safety_distance;
      logic [15:0] min_distance;
      logic [26:0] min_threshold;
      logic [15:0] gain_p;
      logic [15:0] gain_d;
      logic [15:0] start_angle;
      logic [15:0] angle_step;
   } cfg_type;

   // One classified sample, passed from the front to the back.
   typedef struct packed {
      logic        hit;
      logic        last;
      logic [15:0] excess;
      logic [15:0] angle;
   } beat_type;

   // Queue fill status.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Quarter wave sine entry q in Q1.14 for a full circle of 2^tab_bits
   // entries. Only called with constant arguments, so it folds away.
   function automatic logic [14:0] quarter_entry(input int unsigned tab_bits,
                                                 input int unsigned q);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] s;
      x    = ((PI_HALF_Q30 * 64'd4 * 64'(q)) + (64'd1 << (tab_bits - 1))) >> tab_bits;
      x2   = (x * x) >> 30;
      term = x;
      s    = signed'(x);
      // Taylor series up to the x^13 term.
      term = ((term * x2) >> 30) / 64'd6;
      s    = s - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      s    = s + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      s    = s - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      s    = s + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      s    = s - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      s    = s + signed'(term);
      if (s < 0) begin
         s = 0;
      end
      s = (s + 64'sd32768) >>> 16;
      if (s > 64'sd16384) begin
         s = 64'sd16384;
      end
      return s[14:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lrv_front.sv =====
// Front part: accepts range samples, tracks the beam angle and classifies
// each sample as a hit or not. Depends on lrv_pkg.
`default_nettype none

module lrv_front
   import lrv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_range_mm,
   input  wire logic        req_last,
   input  wire logic        q_full,
   output logic             push,
   output beat_type         push_beat
);

   logic [15:0] beam_ff;
   logic [15:0] beam_in;
   logic        accept;

   // The queue decides whether a beat can be taken.
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign push      = accept;

   // Classify the sample and tag it with its beam angle.
   always_comb begin
      push_beat.hit    = (req_range_mm > cfg.min_distance) &&
                         (req_range_mm < cfg.safety_distance);
      push_beat.last   = req_last;
      push_beat.excess = cfg.safety_distance - req_range_mm;
      push_beat.angle  = cfg.start_angle + beam_ff;
   end

   // Beam offset advances per sample and restarts after the last one.
   always_comb begin
      beam_in = beam_ff;
      if (accept) begin
         beam_in = req_last ? 16'd0 : beam_ff + cfg.angle_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beam_ff <= 16'd0;
      end else begin
         beam_ff <= beam_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lrv_queue.sv =====
// Short flip-flop queue between the front and back parts.
// Depends on lrv_pkg for the status struct.
`default_nettype none

module lrv_queue
   import lrv_pkg::*;
#(
   parameter int WIDTH = 34,
   parameter int DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output q_status_type          status
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff;
   logic [IW-1:0]    wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff;
   logic [IW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lrv_back.sv =====
// Back part: sine lookup, repulsion accumulation, scan close-out, PD gains
// and the output register. Depends on lrv_pkg.
`default_nettype none

module lrv_back
   import lrv_pkg::*;
#(
   parameter int TRIG_TABLE_BITS = DEF_TRIG_TABLE_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_empty,
   input  wire beat_type    q_beat,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_active,
   output logic signed [31:0] rsp_roll_cmd,
   output logic signed [31:0] rsp_pitch_cmd
);

   localparam int B  = TRIG_TABLE_BITS;
   localparam int QN = 1 << (B - 2);

   logic [14:0] qtab [QN + 1];

   // Quarter wave table, constant after elaboration.
   for (genvar g = 0; g <= QN; g++) begin : g_qtab
      assign qtab[g] = quarter_entry(B, g);
   end

   // Quadrant folding of a table index onto the quarter wave.
   function automatic logic [B-1:0] fold(input logic [B-1:0] k);
      logic [B-2:0] r;
      r = {1'b0, k[B-3:0]};
      return {k[B-1], (k[B-2] ? (B-1)'(QN) - r : r)};
   endfunction

   // Saturate a 29 bit sum to the 28 bit range.
   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
      if (v[SUM_W] != v[SUM_W-1]) begin
         return v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return v[SUM_W-1:0];
   endfunction

   // Saturate a 47 bit command to 32 bits.
   function automatic logic signed [31:0] sat_cmd(input logic signed [46:0] v);
      if (v[46:31] != {16{v[46]}}) begin
         return v[46] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return v[31:0];
   endfunction

   logic en;

   // The whole back pipeline moves unless the output beat is blocked.
   assign en  = !rsp_valid || !rsp_stall;
   assign pop = en;

   // Stage A: fold sine and cosine indexes.
   logic           a_valid_ff, a_hit_ff, a_last_ff, a_sneg_ff, a_cneg_ff;
   logic [15:0]    a_dist_ff;
   logic [B-2:0]   a_sidx_ff, a_cidx_ff;
   logic [B-1:0]   a_sfold_in, a_cfold_in, a_k;

   always_comb begin
      a_k        = q_beat.angle[15 -: B];
      a_sfold_in = fold(a_k);
      a_cfold_in = fold(a_k + B'(QN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= !q_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_hit_ff  <= q_beat.hit;
         a_last_ff <= q_beat.last;
         a_dist_ff <= q_beat.excess;
         a_sneg_ff <= a_sfold_in[B-1];
         a_sidx_ff <= a_sfold_in[B-2:0];
         a_cneg_ff <= a_cfold_in[B-1];
         a_cidx_ff <= a_cfold_in[B-2:0];
      end
   end

   // Stage B: table lookup.
   logic        b_valid_ff, b_hit_ff, b_last_ff, b_sneg_ff, b_cneg_ff;
   logic [15:0] b_dist_ff;
   logic [14:0] b_sval_ff, b_cval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_hit_ff  <= a_hit_ff;
         b_last_ff <= a_last_ff;
         b_dist_ff <= a_dist_ff;
         b_sneg_ff <= a_sneg_ff;
         b_cneg_ff <= a_cneg_ff;
         b_sval_ff <= qtab[a_sidx_ff];
         b_cval_ff <= qtab[a_cidx_ff];
      end
   end

   // Stage C: distance times table magnitude.
   logic        c_valid_ff, c_hit_ff, c_last_ff, c_sneg_ff, c_cneg_ff;
   logic [30:0] c_smag_ff, c_cmag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_hit_ff  <= b_hit_ff;
         c_last_ff <= b_last_ff;
         c_sneg_ff <= b_sneg_ff;
         c_cneg_ff <= b_cneg_ff;
         c_smag_ff <= b_dist_ff * b_sval_ff;
         c_cmag_ff <= b_dist_ff * b_cval_ff;
      end
   end

   // Stage D: round to whole millimetres and accumulate the scan sums.
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                    hit_ff, hit_in;
   logic                    d_valid_ff, d_hit_ff, d_hit_in;
   logic signed [SUM_W-1:0] d_x_ff, d_y_ff, d_x_in, d_y_in;
   logic [30:0]             rnd_x, rnd_y;
   logic signed [17:0]      term_x, term_y;

   always_comb begin
      rnd_x    = c_cmag_ff + 31'd8192;
      rnd_y    = c_smag_ff + 31'd8192;
      term_x   = c_cneg_ff ? -$signed({1'b0, rnd_x[30:14]}) : $signed({1'b0, rnd_x[30:14]});
      term_y   = c_sneg_ff ? -$signed({1'b0, rnd_y[30:14]}) : $signed({1'b0, rnd_y[30:14]});
      d_x_in   = sum_x_ff;
      d_y_in   = sum_y_ff;
      d_hit_in = hit_ff;
      if (c_hit_ff) begin
         d_x_in   = sat_sum((SUM_W+1)'(sum_x_ff) + (SUM_W+1)'(term_x));
         d_y_in   = sat_sum((SUM_W+1)'(sum_y_ff) + (SUM_W+1)'(term_y));
         d_hit_in = 1'b1;
      end
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      hit_in   = hit_ff;
      if (c_valid_ff) begin
         sum_x_in = c_last_ff ? '0 : d_x_in;
         sum_y_in = c_last_ff ? '0 : d_y_in;
         hit_in   = c_last_ff ? 1'b0 : d_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
         hit_ff     <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         sum_x_ff   <= sum_x_in;
         sum_y_ff   <= sum_y_in;
         hit_ff     <= hit_in;
         d_valid_ff <= c_valid_ff && c_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_hit_ff <= d_hit_in;
         d_x_ff   <= d_x_in;
         d_y_ff   <= d_y_in;
      end
   end

   // Stage E: threshold, activity and change against the previous scan.
   logic signed [SUM_W-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [SUM_W-1:0]        abs_x, abs_y;
   logic signed [SUM_W-1:0] e_x_in, e_y_in, e_x_ff, e_y_ff;
   logic signed [SUM_W:0]   e_dx_ff, e_dy_ff;
   logic                    e_valid_ff, e_active_ff, e_active_in;

   always_comb begin
      abs_x       = d_x_ff[SUM_W-1] ? SUM_W'(-d_x_ff) : SUM_W'(d_x_ff);
      abs_y       = d_y_ff[SUM_W-1] ? SUM_W'(-d_y_ff) : SUM_W'(d_y_ff);
      e_x_in      = (abs_x < {1'b0, cfg.min_threshold}) ? '0 : d_x_ff;
      e_y_in      = (abs_y < {1'b0, cfg.min_threshold}) ? '0 : d_y_ff;
      e_active_in = d_hit_ff && ((e_x_in != '0) || (e_y_in != '0));
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      if (d_valid_ff) begin
         prev_x_in = d_hit_ff ? e_x_in : '0;
         prev_y_in = d_hit_ff ? e_y_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         e_valid_ff <= 1'b0;
      end else if (en) begin
         prev_x_ff  <= prev_x_in;
         prev_y_ff  <= prev_y_in;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_active_ff <= e_active_in;
         e_x_ff      <= e_x_in;
         e_y_ff      <= e_y_in;
         e_dx_ff     <= (SUM_W+1)'(e_x_in) - (SUM_W+1)'(prev_x_ff);
         e_dy_ff     <= (SUM_W+1)'(e_y_in) - (SUM_W+1)'(prev_y_ff);
      end
   end

   // Stage F: proportional and derivative products.
   logic signed [16:0] gp_s, gd_s;
   logic signed [44:0] f_px_ff, f_py_ff, f_px_in, f_py_in;
   logic signed [45:0] f_dxg_ff, f_dyg_ff, f_dxg_in, f_dyg_in;
   logic               f_valid_ff, f_active_ff;

   always_comb begin
      gp_s     = $signed({1'b0, cfg.gain_p});
      gd_s     = $signed({1'b0, cfg.gain_d});
      f_px_in  = e_x_ff * gp_s;
      f_py_in  = e_y_ff * gp_s;
      f_dxg_in = e_dx_ff * gd_s;
      f_dyg_in = e_dy_ff * gd_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_active_ff <= e_active_ff;
         f_px_ff     <= f_px_in;
         f_py_ff     <= f_py_in;
         f_dxg_ff    <= f_dxg_in;
         f_dyg_ff    <= f_dyg_in;
      end
   end

   // Output register: combine, saturate, zero when inactive.
   logic               rsp_valid_ff;
   logic               rsp_active_ff;
   logic signed [31:0] rsp_roll_ff, rsp_pitch_ff, rsp_roll_in, rsp_pitch_in;
   logic signed [46:0] roll_full, pitch_full;

   always_comb begin
      pitch_full   = 47'(f_px_ff) + 47'(f_dxg_ff);
      roll_full    = -47'(f_py_ff) - 47'(f_dyg_ff);
      rsp_roll_in  = f_active_ff ? sat_cmd(roll_full) : 32'sd0;
      rsp_pitch_in = f_active_ff ? sat_cmd(pitch_full) : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en && f_valid_ff) begin
         rsp_active_ff <= f_active_ff;
         rsp_roll_ff   <= rsp_roll_in;
         rsp_pitch_ff  <= rsp_pitch_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_active    = rsp_active_ff;
   assign rsp_roll_cmd  = rsp_roll_ff;
   assign rsp_pitch_cmd = rsp_pitch_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lidar_repulsion_vector_pd_core.sv =====
// Top level of the lidar repulsion vector core: configuration registers,
// front part, queue and back part. Depends on lrv_pkg and all lrv_ modules.
`default_nettype none

// Range samples of one scan enter on the req_ channel at one beat per clock
// while req_stall is low; the beam angle starts at start_angle and advances by
// angle_step for every sample. The sample flagged last closes the scan and
// yields exactly one rsp_ beat with the active flag and the saturated roll and
// pitch commands; rsp_valid rises once that sample has passed the queue,
// stages A to F and the output register. Other samples yield nothing. Unless
// rsp_stall holds the back part, the sustained rate of one sample per cycle
// is set by its single scan accumulator, which adds one rounded sine and
// cosine term per cycle. A queue of QUEUE_DEPTH beats sits between the front and
// back parts, so req_stall rises only once the result side stalls and the queue
// fills. The user must write registers through the csr_ port only while no scan
// is in flight; the core does not enforce it. Writes to unused indexes are ignored.
module lidar_repulsion_vector_pd_core
   import lrv_pkg::*;
#(
   parameter int TRIG_TABLE_BITS = DEF_TRIG_TABLE_BITS,
   parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_range_mm,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_active,
   output logic signed [31:0] rsp_roll_cmd,
   output logic signed [31:0] rsp_pitch_cmd,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         q_push;
   beat_type     q_push_beat;
   beat_type     q_pop_beat;
   logic         q_pop;
   q_status_type q_stat;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_SAFETY_DISTANCE: cfg_in.safety_distance = csr_data[15:0];
            REG_MIN_DISTANCE:    cfg_in.min_distance    = csr_data[15:0];
            REG_MIN_THRESHOLD:   cfg_in.min_threshold   = csr_data[26:0];
            REG_GAIN_P:          cfg_in.gain_p          = csr_data[15:0];
            REG_GAIN_D:          cfg_in.gain_d          = csr_data[15:0];
            REG_START_ANGLE:     cfg_in.start_angle     = csr_data[15:0];
            REG_ANGLE_STEP:      cfg_in.angle_step      = csr_data[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.safety_distance <= RST_SAFETY_DISTANCE;
         cfg_ff.min_distance    <= RST_MIN_DISTANCE;
         cfg_ff.min_threshold   <= RST_MIN_THRESHOLD;
         cfg_ff.gain_p          <= RST_GAIN_P;
         cfg_ff.gain_d          <= RST_GAIN_D;
         cfg_ff.start_angle     <= RST_START_ANGLE;
         cfg_ff.angle_step      <= RST_ANGLE_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front part: classification and beam angle.
   lrv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_range_mm (req_range_mm),
      .req_last     (req_last),
      .q_full       (q_stat.full),
      .push         (q_push),
      .push_beat    (q_push_beat)
   );

   // Queue between the two parts.
   lrv_queue #(
      .WIDTH ($bits(beat_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_beat),
      .pop       (q_pop),
      .pop_data  (q_pop_beat),
      .status    (q_stat)
   );

   // Back part: accumulation, close-out and output.
   lrv_back #(
      .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_empty       (q_stat.empty),
      .q_beat        (q_pop_beat),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_active    (rsp_active),
      .rsp_roll_cmd  (rsp_roll_cmd),
      .rsp_pitch_cmd (rsp_pitch_cmd)
   );

   // The front never pushes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("queue push while full");

   // An inactive result carries zero commands.
   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_active) |-> (rsp_roll_cmd == 32'sd0 && rsp_pitch_cmd == 32'sd0))
      else $error("inactive result with nonzero command");

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The front stalls exactly when the queue is full.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall == q_stat.full)
      else $error("stall does not follow queue fill");

endmodule

`default_nettype wire
